FILE: sv/brfc_pkg.sv
// Shared types, codes and helper functions of the request framer with CRC-16.
package brfc_pkg;

    localparam int IDX_W    = 4;
    localparam int QDEPTH   = 2;
    localparam int QPTR_W   = 1;
    localparam int QCNT_W   = 2;
    localparam int CNT_W    = 7;

    localparam logic [2:0] CMD_WRITE_SINGLE = 3'd0;
    localparam logic [2:0] CMD_READ_REG     = 3'd1;
    localparam logic [2:0] CMD_MB_READ      = 3'd2;
    localparam logic [2:0] CMD_WM_FIRST     = 3'd3;
    localparam logic [2:0] CMD_WM_NEXT      = 3'd4;
    localparam logic [2:0] CMD_READ_EVENTS  = 3'd5;

    localparam logic [2:0] OP_WS  = 3'd0;
    localparam logic [2:0] OP_RR  = 3'd1;
    localparam logic [2:0] OP_MR  = 3'd2;
    localparam logic [2:0] OP_WM  = 3'd3;
    localparam logic [2:0] OP_WV  = 3'd4;
    localparam logic [2:0] OP_RE  = 3'd5;
    localparam logic [2:0] OP_ERR = 3'd6;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_COUNT     = 2'd1;
    localparam logic [1:0] ST_STRAY     = 2'd2;
    localparam logic [1:0] ST_SEQUENCE  = 2'd3;

    localparam logic       CFG_MAX_READ  = 1'b0;
    localparam logic       CFG_MAX_WRITE = 1'b1;

    localparam logic [7:0]  PREAMBLE   = 8'hAA;
    localparam logic [7:0]  OPC_WS     = 8'h0D;
    localparam logic [7:0]  OPC_RR     = 8'h07;
    localparam logic [7:0]  OPC_MR     = 8'h03;
    localparam logic [7:0]  OPC_WM     = 8'h10;
    localparam logic [7:0]  OPC_RE     = 8'h11;
    localparam logic [7:0]  WS_LEN     = 8'h04;
    localparam logic [7:0]  RR_COUNT   = 8'h01;
    localparam logic [15:0] CRC_INIT   = 16'hFFFF;
    localparam logic [15:0] CRC_POLY   = 16'hA001;
    localparam logic [CNT_W-1:0] MAX_READ_RESET  = 7'd127;
    localparam logic [CNT_W-1:0] MAX_WRITE_RESET = 7'd100;

    typedef struct packed {
        logic [2:0]  command;
        logic [15:0] reg_address;
        logic [15:0] reg_value;
        logic [7:0]  reg_count;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       frame_last;
        logic [1:0] status;
    } out_item_t;

    typedef struct packed {
        logic [2:0]       op;
        logic [15:0]      addr;
        logic [15:0]      val;
        logic [7:0]       cnt;
        logic             with_crc;
        logic [IDX_W-1:0] len;
        logic [1:0]       status;
    } job_t;

    function automatic logic [15:0] crc_byte(logic [15:0] crc_in, logic [7:0] b);
        logic [15:0] c;
        c = crc_in ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

    // Data byte of a frame at a given position; CRC bytes are handled elsewhere.
    function automatic logic [7:0] frame_byte(job_t j, logic [IDX_W-1:0] idx);
        logic [7:0] b;
        b = 8'h00;
        case (j.op)
            OP_WS: begin
                case (idx)
                    4'd0: b = PREAMBLE;
                    4'd1: b = OPC_WS;
                    4'd2: b = WS_LEN;
                    4'd3: b = j.addr[7:0];
                    4'd4: b = j.addr[15:8];
                    4'd5: b = j.val[7:0];
                    4'd6: b = j.val[15:8];
                    default: b = 8'h00;
                endcase
            end
            OP_RR: begin
                case (idx)
                    4'd0: b = PREAMBLE;
                    4'd1: b = OPC_RR;
                    4'd2: b = RR_COUNT;
                    4'd3: b = j.addr[7:0];
                    4'd4: b = j.addr[15:8];
                    default: b = 8'h00;
                endcase
            end
            OP_MR, OP_WM: begin
                case (idx)
                    4'd0: b = PREAMBLE;
                    4'd1: b = (j.op == OP_MR) ? OPC_MR : OPC_WM;
                    4'd2: b = j.addr[15:8];
                    4'd3: b = j.addr[7:0];
                    4'd4: b = 8'h00;
                    4'd5: b = j.cnt;
                    4'd6: b = {j.cnt[6:0], 1'b0};
                    4'd7: b = j.val[15:8];
                    4'd8: b = j.val[7:0];
                    default: b = 8'h00;
                endcase
            end
            OP_WV: begin
                case (idx)
                    4'd0: b = j.val[15:8];
                    4'd1: b = j.val[7:0];
                    default: b = 8'h00;
                endcase
            end
            OP_RE: begin
                case (idx)
                    4'd0: b = PREAMBLE;
                    4'd1: b = OPC_RE;
                    default: b = 8'h00;
                endcase
            end
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

FILE: sv/brfc_front.sv
// Front end: accepts commands, checks sequence and counts, and builds frame jobs.
module brfc_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_we,
    input  logic              cfg_index,
    input  logic [6:0]        cfg_wdata,
    input  logic              s_valid,
    output logic              s_ready,
    input  brfc_pkg::in_item_t s_data,
    output logic              push,
    output brfc_pkg::job_t    push_job,
    input  logic              q_full
);
    import brfc_pkg::*;

    logic [CNT_W-1:0] max_read_reg, max_read_next;
    logic [CNT_W-1:0] max_write_reg, max_write_next;
    logic [CNT_W-1:0] values_left_reg, values_left_next;
    logic             write_open_reg, write_open_next;
    logic             accept;
    logic             cnt_bad_rd, cnt_bad_wr;
    logic [CNT_W-1:0] vl_dec;
    job_t             job;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;
    assign vl_dec  = values_left_reg - 7'd1;

    assign cnt_bad_rd = (s_data.reg_count == 8'd0) ||
                        (s_data.reg_count > {1'b0, max_read_reg});
    assign cnt_bad_wr = (s_data.reg_count == 8'd0) ||
                        (s_data.reg_count > {1'b0, max_write_reg});

    always_comb begin
        job          = '0;
        job.addr     = s_data.reg_address;
        job.val      = s_data.reg_value;
        job.cnt      = s_data.reg_count;
        job.with_crc = 1'b1;
        job.status   = ST_OK;
        values_left_next = values_left_reg;
        write_open_next  = write_open_reg;
        push = accept && (s_data.command inside {[CMD_WRITE_SINGLE:CMD_READ_EVENTS]});

        if (s_data.command == CMD_WM_NEXT && !write_open_reg) begin
            job.op = OP_ERR; job.len = 4'd1; job.status = ST_STRAY; job.with_crc = 1'b0;
        end else if (s_data.command != CMD_WM_NEXT && write_open_reg) begin
            job.op = OP_ERR; job.len = 4'd1; job.status = ST_SEQUENCE; job.with_crc = 1'b0;
        end else begin
            case (s_data.command)
                CMD_WRITE_SINGLE: begin
                    job.op = OP_WS; job.len = 4'd9;
                end
                CMD_READ_REG: begin
                    job.op = OP_RR; job.len = 4'd7;
                end
                CMD_MB_READ: begin
                    if (cnt_bad_rd) begin
                        job.op = OP_ERR; job.len = 4'd1; job.status = ST_COUNT;
                        job.with_crc = 1'b0;
                    end else begin
                        job.op = OP_MR; job.len = 4'd8;
                    end
                end
                CMD_WM_FIRST: begin
                    if (cnt_bad_wr) begin
                        job.op = OP_ERR; job.len = 4'd1; job.status = ST_COUNT;
                        job.with_crc = 1'b0;
                    end else if (s_data.reg_count == 8'd1) begin
                        job.op = OP_WM; job.len = 4'd11;
                    end else begin
                        job.op = OP_WM; job.len = 4'd9; job.with_crc = 1'b0;
                        values_left_next = s_data.reg_count[CNT_W-1:0] - 7'd1;
                        write_open_next  = 1'b1;
                    end
                end
                CMD_WM_NEXT: begin
                    values_left_next = vl_dec;
                    if (vl_dec == '0) begin
                        job.op = OP_WV; job.len = 4'd4;
                        write_open_next = 1'b0;
                    end else begin
                        job.op = OP_WV; job.len = 4'd2; job.with_crc = 1'b0;
                    end
                end
                CMD_READ_EVENTS: begin
                    job.op = OP_RE; job.len = 4'd4;
                end
                default: begin
                    job.op = OP_ERR; job.len = 4'd1; job.with_crc = 1'b0;
                end
            endcase
        end
        if (!push) begin
            values_left_next = values_left_reg;
            write_open_next  = write_open_reg;
        end
    end

    assign push_job = job;

    always_comb begin
        max_read_next  = max_read_reg;
        max_write_next = max_write_reg;
        if (cfg_we) begin
            case (cfg_index)
                CFG_MAX_READ:  max_read_next  = cfg_wdata;
                CFG_MAX_WRITE: max_write_next = cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_read_reg    <= MAX_READ_RESET;
            max_write_reg   <= MAX_WRITE_RESET;
            values_left_reg <= '0;
            write_open_reg  <= 1'b0;
        end else begin
            max_read_reg    <= max_read_next;
            max_write_reg   <= max_write_next;
            values_left_reg <= values_left_next;
            write_open_reg  <= write_open_next;
        end
    end

    // An open write always has values still due, and a closed one has none.
    a_open_matches_left: assert property (@(posedge aclk) disable iff (!aresetn)
        write_open_reg == (values_left_reg != '0))
        else $error("write_open and values_left disagree");

endmodule

FILE: sv/brfc_queue.sv
// Two-entry job queue between the front end and the byte sequencer.
module brfc_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  brfc_pkg::job_t push_job,
    output logic           full,
    input  logic           pop,
    output logic           head_valid,
    output brfc_pkg::job_t head
);
    import brfc_pkg::*;

    job_t              mem [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    assign full       = (count_reg == QCNT_W'(QDEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + QCNT_W'(push) - QCNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

FILE: sv/brfc_back.sv
// Back end: walks each job byte by byte, keeps the running CRC and holds the output item.
module brfc_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               head_valid,
    input  brfc_pkg::job_t     head,
    output logic               pop,
    output logic               m_valid,
    input  logic               m_ready,
    output brfc_pkg::out_item_t m_data
);
    import brfc_pkg::*;

    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [15:0]      crc_reg, crc_next;
    logic [7:0]       crc_hold_reg, crc_hold_next;
    logic             m_valid_reg, m_valid_next;
    out_item_t        out_reg, out_next;
    logic             load, last, is_crc_lo, is_crc_hi;
    logic [15:0]      crc_cur;
    logic [7:0]       cur_byte;

    assign load      = head_valid && (!m_valid_reg || m_ready);
    assign last      = (idx_reg == head.len - 4'd1);
    assign is_crc_lo = head.with_crc && (idx_reg == head.len - 4'd2);
    assign is_crc_hi = head.with_crc && last;
    assign crc_cur   = (idx_reg == '0 && head.op != OP_WV) ? CRC_INIT : crc_reg;
    assign pop       = load && last;

    always_comb begin
        if (is_crc_lo) begin
            cur_byte = crc_cur[7:0];
        end else if (is_crc_hi) begin
            cur_byte = crc_hold_reg;
        end else begin
            cur_byte = frame_byte(head, idx_reg);
        end
    end

    always_comb begin
        idx_next      = idx_reg;
        crc_next      = crc_reg;
        crc_hold_next = crc_hold_reg;
        out_next      = out_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        if (load) begin
            m_valid_next        = 1'b1;
            idx_next            = last ? '0 : idx_reg + 4'd1;
            out_next.frame_last = last;
            out_next.status     = head.status;
            if (head.op == OP_ERR) begin
                out_next.out_byte   = 8'h00;
                out_next.byte_valid = 1'b0;
            end else begin
                out_next.out_byte   = cur_byte;
                out_next.byte_valid = 1'b1;
                crc_next            = crc_byte(crc_cur, cur_byte);
                if (is_crc_lo) begin
                    crc_hold_next = crc_cur[15:8];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        out_reg      <= out_next;
        crc_hold_reg <= crc_hold_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg     <= '0;
            crc_reg     <= CRC_INIT;
            m_valid_reg <= 1'b0;
        end else begin
            idx_reg     <= idx_next;
            crc_reg     <= crc_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

    // An error item is a single zero byte that closes its item.
    a_err_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !out_reg.byte_valid |-> out_reg.frame_last && out_reg.out_byte == 8'h00)
        else $error("malformed error item");

    // The byte position never runs past the length of the job at the head.
    a_idx_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        head_valid |-> idx_reg < head.len)
        else $error("byte index beyond job length");

    // A job is started afresh only after the previous one was popped.
    a_pop_resets_idx: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |=> idx_reg == '0)
        else $error("byte index not cleared after job end");

    // Frame bytes report an ok status.
    a_ok_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && out_reg.byte_valid |-> out_reg.status == ST_OK)
        else $error("frame byte with error status");

endmodule

FILE: sv/bms_request_framer_crc16_top.sv
// Top level of the serial request framer with CRC-16.
// The first item of a command is registered in the job queue and then in the output register.
// Throughput: one output item per cycle while m_ready stays high and a job is queued; a
// command yields up to 11 items, none for the unused codes. A two-job queue lets the input
// side run ahead of the output by up to two commands.
// Reset: synchronous active-low aresetn clears the queue, the sequence state and the CRC.
module bms_request_framer_crc16_top (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_we,
    input  logic                cfg_index,
    input  logic [6:0]          cfg_wdata,
    input  logic                s_valid,
    output logic                s_ready,
    input  brfc_pkg::in_item_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output brfc_pkg::out_item_t m_data
);
    import brfc_pkg::*;

    logic push, q_full, pop, head_valid;
    job_t push_job, head;

    brfc_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .push     (push),
        .push_job (push_job),
        .q_full   (q_full)
    );

    brfc_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_job  (push_job),
        .full      (q_full),
        .pop       (pop),
        .head_valid(head_valid),
        .head      (head)
    );

    brfc_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .head_valid(head_valid),
        .head      (head),
        .pop       (pop),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

FILE: tb/sv/testbench.sv
// Self-checking testbench for the CRC-16 request framer: predicted frame bytes vs. output.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import brfc_pkg::*;

    localparam logic [2:0] CMD_SPARE_LO  = 3'd6;
    localparam logic [2:0] CMD_SPARE_HI  = 3'd7;
    localparam int         SETTLE_CYCLES = 30;
    localparam int         QUIET_LIMIT   = 3000;
    localparam int         HOLD_CYCLES   = 400;

    class frame_scoreboard;
        logic [6:0]  max_read;
        logic [6:0]  max_write;
        logic [15:0] crc;
        logic [6:0]  values_left;
        bit          write_open;
        out_item_t   frame_bytes[$];
        int          mismatches;

        function new();
            max_read    = MAX_READ_RESET;
            max_write   = MAX_WRITE_RESET;
            crc         = CRC_INIT;
            values_left = '0;
            write_open  = 0;
            mismatches  = 0;
        endfunction

        function void set_limit(logic idx, logic [6:0] v);
            if (idx == CFG_MAX_READ) begin
                max_read = v;
            end else begin
                max_write = v;
            end
        endfunction

        function void emit(logic [7:0] b);
            logic [15:0] c;
            out_item_t r;
            c = crc ^ {8'h00, b};
            for (int k = 0; k < 8; k++) begin
                c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
            end
            crc = c;
            r.out_byte   = b;
            r.byte_valid = 1'b1;
            r.frame_last = 1'b0;
            r.status     = ST_OK;
            frame_bytes.push_back(r);
        endfunction

        function void open_frame(logic [7:0] opcode);
            crc = CRC_INIT;
            emit(PREAMBLE);
            emit(opcode);
        endfunction

        function void emit_crc();
            logic [15:0] c;
            c = crc;
            emit(c[7:0]);
            emit(c[15:8]);
        endfunction

        function void reject(logic [1:0] code);
            out_item_t r;
            r.out_byte   = 8'h00;
            r.byte_valid = 1'b0;
            r.frame_last = 1'b1;
            r.status     = code;
            frame_bytes.push_back(r);
        endfunction

        function void take_command(in_item_t it);
            int first;
            logic [7:0] doubled;
            first   = frame_bytes.size();
            doubled = it.reg_count << 1;
            if (it.command > CMD_READ_EVENTS) begin
                return;
            end
            if (it.command == CMD_WM_NEXT) begin
                if (!write_open) begin
                    reject(ST_STRAY);
                    return;
                end
            end else if (write_open) begin
                reject(ST_SEQUENCE);
                return;
            end
            case (it.command)
                CMD_WRITE_SINGLE: begin
                    open_frame(OPC_WS);
                    emit(WS_LEN);
                    emit(it.reg_address[7:0]);
                    emit(it.reg_address[15:8]);
                    emit(it.reg_value[7:0]);
                    emit(it.reg_value[15:8]);
                    emit_crc();
                end
                CMD_READ_REG: begin
                    open_frame(OPC_RR);
                    emit(RR_COUNT);
                    emit(it.reg_address[7:0]);
                    emit(it.reg_address[15:8]);
                    emit_crc();
                end
                CMD_MB_READ: begin
                    if (it.reg_count == 8'd0 || it.reg_count > {1'b0, max_read}) begin
                        reject(ST_COUNT);
                        return;
                    end
                    open_frame(OPC_MR);
                    emit(it.reg_address[15:8]);
                    emit(it.reg_address[7:0]);
                    emit(8'h00);
                    emit(it.reg_count);
                    emit_crc();
                end
                CMD_WM_FIRST: begin
                    if (it.reg_count == 8'd0 || it.reg_count > {1'b0, max_write}) begin
                        reject(ST_COUNT);
                        return;
                    end
                    open_frame(OPC_WM);
                    emit(it.reg_address[15:8]);
                    emit(it.reg_address[7:0]);
                    emit(8'h00);
                    emit(it.reg_count);
                    emit(doubled);
                    emit(it.reg_value[15:8]);
                    emit(it.reg_value[7:0]);
                    if (it.reg_count == 8'd1) begin
                        emit_crc();
                    end else begin
                        values_left = 7'(it.reg_count - 8'd1);
                        write_open  = 1;
                    end
                end
                CMD_WM_NEXT: begin
                    emit(it.reg_value[15:8]);
                    emit(it.reg_value[7:0]);
                    values_left = values_left - 7'd1;
                    if (values_left == 7'd0) begin
                        write_open = 0;
                        emit_crc();
                    end
                end
                default: begin
                    open_frame(OPC_RE);
                    emit_crc();
                end
            endcase
            if (frame_bytes.size() > first) begin
                frame_bytes[frame_bytes.size() - 1].frame_last = 1'b1;
            end
        endfunction

        function void note_mismatch(string what, out_item_t want, out_item_t got);
            mismatches++;
            if (mismatches <= 10) begin
                $display("%0t: %s: expected %02h v%0b l%0b s%0d, actual %02h v%0b l%0b s%0d",
                         $realtime, what, want.out_byte, want.byte_valid, want.frame_last,
                         want.status, got.out_byte, got.byte_valid, got.frame_last,
                         got.status);
            end
        endfunction

        function void check_byte(out_item_t got);
            out_item_t want;
            if (frame_bytes.size() == 0) begin
                want = '0;
                note_mismatch("unexpected item", want, got);
                return;
            end
            want = frame_bytes.pop_front();
            if (got.out_byte !== want.out_byte || got.byte_valid !== want.byte_valid ||
                got.frame_last !== want.frame_last || got.status !== want.status) begin
                note_mismatch("wrong item", want, got);
            end
        endfunction
    endclass

    logic      aclk;
    logic      aresetn;
    logic      cfg_we;
    logic      cfg_index;
    logic [6:0] cfg_wdata;
    logic      s_valid;
    logic      s_ready;
    in_item_t  s_data;
    logic      m_valid;
    logic      m_ready;
    out_item_t m_data;

    frame_scoreboard sb = new();
    bit in_calm;
    bit out_calm;
    bit hold_req;
    int quiet_cycles;

    bms_request_framer_crc16_top uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            sb.check_byte(m_data);
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("testbench failed");
                $finish;
            end
        end
    end

    function automatic int next_gap(bit calm);
        return calm ? 0 : $urandom_range(0, 19);
    endfunction

    // Result side: random stalls per item, plus one long hold-off on request.
    initial begin : receiver
        int gap;
        m_ready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            if ($urandom_range(0, 29) == 0) begin
                out_calm = !out_calm;
            end
            gap = next_gap(out_calm);
            if (hold_req) begin
                hold_req = 0;
                gap = HOLD_CYCLES;
            end
            @(negedge aclk);
            if (gap > 0) begin
                m_ready = 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_ready = 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    task automatic send_item(in_item_t it);
        int gap;
        if ($urandom_range(0, 29) == 0) begin
            in_calm = !in_calm;
        end
        gap = next_gap(in_calm);
        @(negedge aclk);
        if (gap > 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid = 1'b1;
        s_data  = it;
        do @(posedge aclk); while (!s_ready);
        sb.take_command(it);
    endtask

    task automatic offer(logic [2:0] cmd, logic [15:0] addr, logic [15:0] val, logic [7:0] cnt);
        in_item_t it;
        it.command     = cmd;
        it.reg_address = addr;
        it.reg_value   = val;
        it.reg_count   = cnt;
        send_item(it);
    endtask

    task automatic drain();
        @(negedge aclk);
        s_valid = 1'b0;
        while (sb.frame_bytes.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_limits(logic [6:0] rd, logic [6:0] wr);
        @(negedge aclk);
        cfg_we    = 1'b1;
        cfg_index = CFG_MAX_READ;
        cfg_wdata = rd;
        @(negedge aclk);
        cfg_index = CFG_MAX_WRITE;
        cfg_wdata = wr;
        @(negedge aclk);
        cfg_we = 1'b0;
        sb.set_limit(CFG_MAX_READ, rd);
        sb.set_limit(CFG_MAX_WRITE, wr);
    endtask

    // Mostly small valid counts, sometimes the boundaries and out-of-range values.
    function automatic logic [7:0] pick_count(logic [6:0] lim);
        int lo;
        lo = lim;
        case ($urandom_range(0, 9))
            0: return 8'd0;
            1: return (lim > 12) ? 8'd12 : {1'b0, lim};
            2: return 8'(lo + 1);
            3: return 8'($urandom_range(lo + 1, 255));
            default: return 8'($urandom_range(1, (lo < 2) ? 1 : ((lo > 6) ? 6 : lo)));
        endcase
    endfunction

    task automatic run_random(int n_items);
        int sent;
        int pick;
        in_item_t it;
        sent = 0;
        while (sent < n_items) begin
            it.reg_address = 16'($urandom);
            it.reg_value   = 16'($urandom);
            it.reg_count   = 8'($urandom);
            pick = $urandom_range(0, 99);
            if (sb.write_open && pick < 85) begin
                it.command = CMD_WM_NEXT;
            end else if (pick < 4) begin
                it.command = $urandom_range(0, 1) ? CMD_SPARE_HI : CMD_SPARE_LO;
            end else begin
                pick = $urandom_range(0, 99);
                if (pick < 35) begin
                    it.command   = CMD_WM_FIRST;
                    it.reg_count = pick_count(sb.max_write);
                end else if (pick < 55) begin
                    it.command   = CMD_MB_READ;
                    it.reg_count = pick_count(sb.max_read);
                end else if (pick < 63) begin
                    it.command = CMD_WM_NEXT;
                end else begin
                    case ($urandom_range(0, 2))
                        0: it.command = CMD_WRITE_SINGLE;
                        1: it.command = CMD_READ_REG;
                        default: it.command = CMD_READ_EVENTS;
                    endcase
                end
            end
            send_item(it);
            if (it.command <= CMD_READ_EVENTS) begin
                sent++;
            end
        end
    endtask

    initial begin
        aresetn   = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = CFG_MAX_READ;
        cfg_wdata = '0;
        s_valid   = 1'b0;
        s_data    = '0;
        in_calm   = 0;
        out_calm  = 0;
        hold_req  = 0;
        quiet_cycles = 0;
        repeat (12) @(negedge aclk);
        aresetn = 1'b1;

        // Directed items at the reset limits.
        offer(CMD_WRITE_SINGLE, 16'h0000, 16'h0000, 8'hFF);
        offer(CMD_WRITE_SINGLE, 16'hFFFF, 16'hFFFF, 8'h00);
        offer(CMD_READ_REG, 16'h1234, 16'($urandom), 8'($urandom));
        offer(CMD_READ_REG, 16'hFFFF, 16'($urandom), 8'($urandom));
        offer(CMD_MB_READ, 16'h0000, 16'($urandom), 8'd1);
        offer(CMD_MB_READ, 16'hFFFF, 16'($urandom), 8'd127);
        offer(CMD_MB_READ, 16'($urandom), 16'($urandom), 8'd0);
        offer(CMD_MB_READ, 16'($urandom), 16'($urandom), 8'd128);
        offer(CMD_MB_READ, 16'($urandom), 16'($urandom), 8'd255);
        offer(CMD_READ_EVENTS, 16'($urandom), 16'($urandom), 8'($urandom));
        offer(CMD_WM_NEXT, 16'($urandom), 16'($urandom), 8'($urandom));
        offer(CMD_WM_FIRST, 16'h8001, 16'hFFFF, 8'd1);
        offer(CMD_WM_FIRST, 16'($urandom), 16'($urandom), 8'd101);
        offer(CMD_WM_FIRST, 16'($urandom), 16'($urandom), 8'd0);
        offer(CMD_WM_FIRST, 16'hABCD, 16'h0000, 8'd3);
        offer(CMD_MB_READ, 16'($urandom), 16'($urandom), 8'd0);
        offer(CMD_WRITE_SINGLE, 16'($urandom), 16'($urandom), 8'($urandom));
        offer(CMD_READ_REG, 16'($urandom), 16'($urandom), 8'($urandom));
        offer(CMD_WM_FIRST, 16'($urandom), 16'($urandom), 8'd2);
        offer(CMD_READ_EVENTS, 16'($urandom), 16'($urandom), 8'($urandom));
        offer(CMD_WM_NEXT, 16'($urandom), 16'h5AA5, 8'($urandom));
        offer(CMD_SPARE_LO, 16'($urandom), 16'($urandom), 8'($urandom));
        offer(CMD_WM_NEXT, 16'($urandom), 16'hFFFF, 8'($urandom));
        offer(CMD_SPARE_HI, 16'hFFFF, 16'hFFFF, 8'hFF);
        drain();

        set_limits(7'd1, 7'd1);
        run_random(20);
        drain();

        set_limits(7'd0, 7'd0);
        run_random(12);
        drain();

        set_limits(7'd127, 7'd127);
        in_calm  = 1;
        hold_req = 1;
        run_random(32);
        drain();

        set_limits(7'($urandom_range(1, 126)), 7'($urandom_range(2, 12)));
        run_random(34);
        drain();

        if (sb.mismatches == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

endmodule
